FILE: sv/b2dec_pkg.sv
// ----------------------------------------------------------------------------
// b2dec_pkg
// Shared types and constants for the binary128 to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2dec_pkg;

  localparam int VALUE_BITS  = 128;
  localparam int DIGIT_COUNT = 39;
  localparam int HALF_BITS   = 64;
  localparam int IN_BITS     = 2 * HALF_BITS;
  localparam int BCD_BITS    = 4 * DIGIT_COUNT;
  localparam int BIT_CNT_W   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int DIG_CNT_W   = $clog2(DIGIT_COUNT + 1);
  localparam int CHAR_BITS   = 6;

  localparam logic [CHAR_BITS-1:0] ASCII_ZERO = CHAR_BITS'(48);
  localparam logic [3:0]           DIGIT_FIVE = 4'd5;

  typedef struct packed {
    logic [HALF_BITS-1:0] value_high;
    logic [HALF_BITS-1:0] value_low;
  } in_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] digit_char;
    logic                 last_digit;
  } out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic skip;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic bit_last;
    logic top_zero;
    logic dig_last;
    logic out_free;
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

endpackage

FILE: sv/b2dec_ctrl.sv
// ----------------------------------------------------------------------------
// b2dec_ctrl
// Sequencer: conversion, leading-zero skip and digit emission phases.
// ----------------------------------------------------------------------------
module b2dec_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  b2dec_pkg::status_t  status,
  output b2dec_pkg::cmd_t     cmd
);

  b2dec_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= b2dec_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == b2dec_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      b2dec_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = b2dec_pkg::ST_CONV;
        end
      end
      b2dec_pkg::ST_CONV: begin
        cmd.step = 1'b1;
        if (status.bit_last) begin
          state_nxt = b2dec_pkg::ST_SKIP;
        end
      end
      b2dec_pkg::ST_SKIP: begin
        if (status.top_zero && !status.dig_last) begin
          cmd.skip = 1'b1;
        end else begin
          state_nxt = b2dec_pkg::ST_EMIT;
        end
      end
      b2dec_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.dig_last) begin
            state_nxt = b2dec_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = b2dec_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/b2dec_dpath.sv
// ----------------------------------------------------------------------------
// b2dec_dpath
// Value shifter, BCD doubling register, counters and output register.
// ----------------------------------------------------------------------------
module b2dec_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  b2dec_pkg::in_t      in_data,
  input  b2dec_pkg::cmd_t     cmd,
  output b2dec_pkg::status_t  status,
  output logic                out_valid,
  input  logic                out_ready,
  output b2dec_pkg::out_t     out_data
);

  localparam int VB = b2dec_pkg::VALUE_BITS;
  localparam int BB = b2dec_pkg::BCD_BITS;
  localparam int DC = b2dec_pkg::DIGIT_COUNT;

  logic [VB-1:0]                    value_r;
  logic [BB-1:0]                    bcd_r, bcd_dbl;
  logic [BB-1:0]                    bcd_prev;
  logic [b2dec_pkg::BIT_CNT_W-1:0]  bit_cnt_r;
  logic [b2dec_pkg::DIG_CNT_W-1:0]  dig_rem_r;
  logic                             out_valid_r;
  b2dec_pkg::out_t                  out_data_r;
  logic [b2dec_pkg::IN_BITS-1:0]    in_word;
  logic [3:0]                       top_dig;

  assign in_word  = {in_data.value_high, in_data.value_low};
  assign top_dig  = bcd_r[BB-1 -: 4];
  // digit i of bcd_prev is digit i-1 of bcd_r
  assign bcd_prev = {bcd_r[BB-5:0], 4'b0000};

  // doubling with carry in; carry out of a digit is simply digit >= 5
  always_comb begin
    for (int i = 0; i < DC; i++) begin
      logic [3:0] d;
      logic [3:0] r;
      logic       cin;
      d   = bcd_r[4*i +: 4];
      r   = (d >= b2dec_pkg::DIGIT_FIVE) ? (d - b2dec_pkg::DIGIT_FIVE) : d;
      cin = (i == 0) ? value_r[VB-1]
                     : (bcd_prev[4*i +: 4] >= b2dec_pkg::DIGIT_FIVE);
      bcd_dbl[4*i +: 4] = {r[2:0], cin};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r   <= in_word[VB-1:0];
      bcd_r     <= '0;
      bit_cnt_r <= b2dec_pkg::BIT_CNT_W'(VB - 1);
      dig_rem_r <= b2dec_pkg::DIG_CNT_W'(DC);
    end else if (cmd.step) begin
      value_r   <= value_r << 1;
      bcd_r     <= bcd_dbl;
      bit_cnt_r <= bit_cnt_r - 1'b1;
    end else if (cmd.skip || cmd.emit) begin
      bcd_r     <= bcd_r << 4;
      dig_rem_r <= dig_rem_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.digit_char <= b2dec_pkg::ASCII_ZERO
                               + {{(b2dec_pkg::CHAR_BITS-4){1'b0}}, top_dig};
      out_data_r.last_digit <= (dig_rem_r == b2dec_pkg::DIG_CNT_W'(1));
    end
  end

  assign status.bit_last = (bit_cnt_r == '0);
  assign status.top_zero = (top_dig == 4'd0);
  assign status.dig_last = (dig_rem_r == b2dec_pkg::DIG_CNT_W'(1));
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: sv/binary128_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary128_to_decimal_ascii
// Unsigned 128-bit binary to decimal ASCII converter, leading zeros dropped.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in_     | in  | in_valid / in_ready   | value_high, value_low
//  out_    | out | out_valid / out_ready | digit_char, last_digit (per digit)
//
//  One transaction: a load, doubling of all 128 bits (one bit per cycle),
//  a skip of up to 38 leading zeros, then emission of one digit per cycle
//  while out_ready allows. The bit-serial doubling takes most of the time.
//  in_ready is high only between transactions; out_ready low stalls emission.
//  Synchronous active-low reset clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module binary128_to_decimal_ascii (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  b2dec_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output b2dec_pkg::out_t  out_data
);

  b2dec_pkg::cmd_t    cmd;
  b2dec_pkg::status_t status;

  b2dec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  b2dec_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high straight after an accepted transaction");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_digit |=> !out_valid)
    else $error("result offered straight after the last digit");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.digit_char >= 6'd48) && (out_data.digit_char <= 6'd57))
    else $error("digit character out of range");

  a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !in_ready)
    else $error("input ready during digit emission");

endmodule
